>>> hw/rtl/gsvt_pkg.sv
// shared constants, codes and types for the growable stack vector table
package gsvt_pkg;

	// storage geometry
	localparam int DEPTH      = 1024;
	localparam int WORD_WIDTH = 32;
	localparam int ADDR_W     = $clog2(DEPTH);

	// fixed field widths
	localparam int CNT_W  = 11;
	localparam int IDX_W  = 10;
	localparam int VAL_W  = 32;
	localparam int STAT_W = 3;

	// request codes
	typedef enum logic [1:0] {
		REQ_APPEND = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_GET    = 2'd2,
		REQ_SET    = 2'd3
	} req_t;

	// result status codes
	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 3'd0,
		ST_NULL      = 3'd1,
		ST_OVERFLOW  = 3'd2,
		ST_ALLOC     = 3'd3,
		ST_UNDERFLOW = 3'd4,
		ST_BOUNDS    = 3'd5
	} status_t;

	// configuration register indexes
	typedef enum logic {
		CFG_INIT_CAP = 1'b0,
		CFG_BLOCK    = 1'b1
	} cfg_idx_t;

	// memory access issued for one request
	typedef struct packed {
		logic                  we;
		logic                  re;
		logic [ADDR_W-1:0]     addr;
		logic [WORD_WIDTH-1:0] wdata;
	} mem_req_t;

	// result fields decided for one request
	typedef struct packed {
		status_t          status;
		logic             rd_en;
		logic [CNT_W-1:0] count;
		logic [CNT_W-1:0] cap;
	} result_t;

endpackage

>>> hw/rtl/gsvt_ram.sv
// generic single-port word memory with registered read
module gsvt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

>>> hw/rtl/gsvt_ctrl.sv
// configuration, item count, capacity and per-request decision logic
module gsvt_ctrl
	import gsvt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CNT_W-1:0] cfg_wdata,
	input  logic             valid,
	input  logic [1:0]       req_type,
	input  logic [IDX_W-1:0] index,
	input  logic [VAL_W-1:0] value,
	output mem_req_t         mem_req,
	output result_t          result
);

	localparam logic [CNT_W:0]   DEPTH_X = (CNT_W + 1)'(DEPTH);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

	logic [CNT_W-1:0] init_cap_q;
	logic [CNT_W-1:0] block_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] cap_q;

	logic [CNT_W-1:0] count_d;
	logic [CNT_W-1:0] cap_d;
	logic [CNT_W-1:0] cnt_dec;
	logic [CNT_W:0]   grown;
	logic [CNT_W:0]   spare;
	logic             uninit;
	logic             null_val;
	logic             idx_oob;
	logic [CNT_W-1:0] cfg_cap;

	assign uninit   = (init_cap_q == '0) && (block_q == '0);
	assign null_val = (value[WORD_WIDTH-1:0] == '0);
	assign idx_oob  = ({1'b0, index} >= count_q);
	assign cnt_dec  = count_q - CNT_W'(1);
	assign grown    = {1'b0, cap_q} + {1'b0, block_q};
	assign spare    = {1'b0, cap_q} - {1'b0, cnt_dec};
	assign cfg_cap  = (cfg_wdata > DEPTH_C) ? DEPTH_C : cfg_wdata;

	// decide status, next count and capacity, and the memory access
	always_comb begin
		count_d       = count_q;
		cap_d         = cap_q;
		mem_req.we    = 1'b0;
		mem_req.re    = 1'b0;
		mem_req.addr  = count_q[ADDR_W-1:0];
		mem_req.wdata = value[WORD_WIDTH-1:0];
		result.status = ST_OK;
		result.rd_en  = 1'b0;
		if (uninit) begin
			result.status = ST_NULL;
		end else begin
			case (req_t'(req_type))
				REQ_APPEND: begin
					if (null_val) begin
						result.status = ST_NULL;
					end else if (count_q >= cap_q && block_q == '0) begin
						result.status = ST_OVERFLOW;
					end else if (count_q >= cap_q && grown > DEPTH_X) begin
						result.status = ST_ALLOC;
					end else begin
						if (count_q >= cap_q) begin
							cap_d = grown[CNT_W-1:0];
						end
						if (count_q < DEPTH_C) begin
							mem_req.we = valid;
							count_d    = count_q + CNT_W'(1);
						end
					end
				end
				REQ_REMOVE: begin
					if (count_q == '0) begin
						result.status = ST_UNDERFLOW;
					end else begin
						count_d      = cnt_dec;
						mem_req.addr = cnt_dec[ADDR_W-1:0];
						mem_req.re   = valid;
						result.rd_en = 1'b1;
						if (cap_q > init_cap_q && spare >= {block_q, 1'b0}) begin
							cap_d = cap_q - block_q;
						end
					end
				end
				REQ_GET: begin
					if (idx_oob) begin
						result.status = ST_BOUNDS;
					end else begin
						mem_req.addr = index[ADDR_W-1:0];
						mem_req.re   = valid;
						result.rd_en = 1'b1;
					end
				end
				REQ_SET: begin
					if (null_val) begin
						result.status = ST_NULL;
					end else if (idx_oob) begin
						result.status = ST_BOUNDS;
					end else begin
						mem_req.addr = index[ADDR_W-1:0];
						mem_req.we   = valid;
					end
				end
				default: begin
					result.status = ST_NULL;
				end
			endcase
		end
		result.count = count_d;
		result.cap   = cap_d;
	end

	// configuration and vector state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_cap_q <= CNT_W'(16);
			block_q    <= CNT_W'(16);
			count_q    <= '0;
			cap_q      <= CNT_W'(16);
		end else if (cfg_we) begin
			if (cfg_idx_t'(cfg_index) == CFG_INIT_CAP) begin
				init_cap_q <= cfg_cap;
				count_q    <= '0;
				cap_q      <= cfg_cap;
			end else begin
				block_q <= cfg_wdata;
			end
		end else if (valid) begin
			count_q <= count_d;
			cap_q   <= cap_d;
		end
	end

endmodule

>>> hw/rtl/growable_stack_vector_table_core.sv
// Growable word vector: append, remove, get and set on a block-grown stack of words.
// A request is taken in every clock cycle (busy stays low). The request register loads at
// the transfer edge; the next edge loads the result register and the registered read of
// the word memory together. So done comes from the result register and rises with the
// result it holds. Results cannot be stalled. The word memory has no clearing pass; only
// entries that were written are ever read.
module growable_stack_vector_table_core
	import gsvt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        req_type,
	input  logic [IDX_W-1:0]  index,
	input  logic [VAL_W-1:0]  value,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [CNT_W-1:0]  cfg_wdata,
	output logic              done,
	output logic [STAT_W-1:0] status,
	output logic [VAL_W-1:0]  read_value,
	output logic [CNT_W-1:0]  item_count,
	output logic [CNT_W-1:0]  capacity
);

	logic             valid_s1;
	logic [1:0]       req_type_s1;
	logic [IDX_W-1:0] index_s1;
	logic [VAL_W-1:0] value_s1;

	logic             done_s2;
	result_t          result_s2;

	mem_req_t              mem_req;
	result_t               result;
	logic [WORD_WIDTH-1:0] rdata;

	assign busy = 1'b0;

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_type_s1 <= req_type;
			index_s1    <= index;
			value_s1    <= value;
		end
	end

	gsvt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.valid     (valid_s1),
		.req_type  (req_type_s1),
		.index     (index_s1),
		.value     (value_s1),
		.mem_req   (mem_req),
		.result    (result)
	);

	gsvt_ram #(
		.WIDTH (WORD_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.re    (mem_req.re),
		.addr  (mem_req.addr),
		.wdata (mem_req.wdata),
		.rdata (rdata)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_s2 <= result;
		end
	end

	// result ports, read word only where the request read memory
	assign done       = done_s2;
	assign status     = result_s2.status;
	assign read_value = result_s2.rd_en ? VAL_W'(rdata) : '0;
	assign item_count = result_s2.count;
	assign capacity   = result_s2.cap;

endmodule
